>>> sv/bzc_pkg.sv
// ----------------------------------------------------------------------------
// bzc_pkg: shared types, constants and functions
// Holds the group-reverse substitution constants, the register index codes,
// the controller/datapath command and status structs, and lookup functions.
// ----------------------------------------------------------------------------
package bzc_pkg;

  localparam int unsigned MAX_DIGITS    = 6;
  localparam int unsigned ALPHABET_SIZE = 25;
  localparam int unsigned TABLE_ENTRIES = 25;
  localparam int unsigned GROUP_DEPTH   = 9;
  localparam int unsigned KEY_SLOTS     = 6;
  localparam int unsigned DIGIT_CAP     = (MAX_DIGITS < KEY_SLOTS) ? MAX_DIGITS : KEY_SLOTS;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned CFG_W    = 50;
  localparam int unsigned KEY_W    = 24;
  localparam int unsigned TAB_C_W  = 25;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned FILL_W   = $clog2(GROUP_DEPTH + 1);
  localparam int unsigned SLOT_W   = $clog2(GROUP_DEPTH);

  typedef enum logic [IDX_W-1:0] {
    CFG_TAB_A   = 3'd0,
    CFG_TAB_B   = 3'd1,
    CFG_TAB_C   = 3'd2,
    CFG_KEY     = 3'd3,
    CFG_DIG_CNT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ST_FILL  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic group_done;
    logic idx_zero;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [FILL_W-1:0] len;
    logic [CNT_W-1:0]  ptr;
  } grp_t;

  // Maps a letter through the loaded table; letters beyond the table pass.
  function automatic logic [LETTER_W-1:0] sub_lookup(
    input logic [LETTER_W-1:0] letter,
    input logic [CFG_W-1:0]    tab_a,
    input logic [CFG_W-1:0]    tab_b,
    input logic [TAB_C_W-1:0]  tab_c
  );
    logic [2*CFG_W+TAB_C_W-1:0] tab;
    logic [6:0]                 bit_pos;
    tab     = {tab_c, tab_b, tab_a};
    bit_pos = {2'b00, letter} * 7'd5;
    if ((32'(letter) >= ALPHABET_SIZE) || (32'(letter) >= TABLE_ENTRIES)) begin
      return letter;
    end
    return tab[bit_pos +: LETTER_W];
  endfunction

  // Finds the next nonzero key digit from the pointer on, cycling over the
  // digits in use. An all-zero key gives groups of one.
  function automatic grp_t next_group(
    input logic [KEY_W-1:0] key,
    input logic [CNT_W-1:0] dig_cnt,
    input logic [CNT_W-1:0] ptr
  );
    grp_t                res;
    logic [CNT_W-1:0]    cnt;
    logic [CNT_W-1:0]    p;
    logic [CNT_W-1:0]    p_nxt;
    logic [3:0]          d;
    logic                found;
    cnt = (dig_cnt == '0) ? CNT_W'(1) : dig_cnt;
    if (32'(cnt) > DIGIT_CAP) cnt = CNT_W'(DIGIT_CAP);
    p = (ptr >= cnt) ? '0 : ptr;
    res.len = FILL_W'(1);
    res.ptr = p;
    found   = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if ((k < 32'(cnt)) && !found) begin
        d     = key[{p, 2'b00} +: 4];
        p_nxt = p + CNT_W'(1);
        p     = (p_nxt == cnt) ? '0 : p_nxt;
        if (d != 4'd0) begin
          found   = 1'b1;
          res.len = (32'(d) > GROUP_DEPTH) ? FILL_W'(GROUP_DEPTH) : FILL_W'(d);
          res.ptr = p;
        end
      end
    end
    return res;
  endfunction

endpackage

>>> sv/bzc_if.sv
// ----------------------------------------------------------------------------
// bzc_if: request channels of the group-reverse substitution block
// Input channel carries a letter and the message end flag; output channel
// carries a substituted letter and the last-letter flag.
// ----------------------------------------------------------------------------
interface bzc_in_if;
  import bzc_pkg::*;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter_in;
  logic                message_end;

  modport source (output valid, letter_in, message_end, input ready);
  modport sink   (input valid, letter_in, message_end, output ready);
endinterface

interface bzc_out_if;
  import bzc_pkg::*;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter_out;
  logic                last_out;

  modport source (output valid, letter_out, last_out, input ready);
  modport sink   (input valid, letter_out, last_out, output ready);
endinterface

>>> sv/bzc_ctrl.sv
// ----------------------------------------------------------------------------
// bzc_ctrl: fill/drain controller
// Accepts letters while a group fills, then drains the group in reverse.
// ----------------------------------------------------------------------------
module bzc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bzc_pkg::dp_sts_t    sts_i,
  output bzc_pkg::ctrl_cmd_t  cmd_o
);
  import bzc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_valid_i && sts_i.group_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.out_free && sts_i.idx_zero) state_d = ST_FILL;
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DRAIN: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/bzc_dp.sv
// ----------------------------------------------------------------------------
// bzc_dp: datapath of the group-reverse substitution block
// Configuration registers, substitution, group store, group length tracking
// and the output register.
// ----------------------------------------------------------------------------
module bzc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bzc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [bzc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [bzc_pkg::LETTER_W-1:0]  letter_i,
  input  logic                          message_end_i,
  input  bzc_pkg::ctrl_cmd_t            cmd_i,
  output bzc_pkg::dp_sts_t              sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bzc_pkg::LETTER_W-1:0]  out_letter_o,
  output logic                          out_last_o
);
  import bzc_pkg::*;

  logic [CFG_W-1:0]    tab_a_q, tab_b_q;
  logic [TAB_C_W-1:0]  tab_c_q;
  logic [KEY_W-1:0]    key_q;
  logic [CNT_W-1:0]    dig_cnt_q;

  logic [LETTER_W-1:0] store_q [GROUP_DEPTH];
  logic [FILL_W-1:0]   fill_q, len_q;
  logic [CNT_W-1:0]    ptr_q;
  logic [FILL_W-1:0]   idx_q;
  logic                end_q;

  logic                out_valid_q;
  logic [LETTER_W-1:0] out_letter_q;
  logic                out_last_q;

  grp_t                grp;
  logic [FILL_W-1:0]   len_eff;
  logic [FILL_W-1:0]   fill_nxt;
  logic [LETTER_W-1:0] sub_letter;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_a_q   <= '0;
      tab_b_q   <= '0;
      tab_c_q   <= '0;
      key_q     <= '0;
      dig_cnt_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TAB_A:   tab_a_q   <= cfg_data_i;
        CFG_TAB_B:   tab_b_q   <= cfg_data_i;
        CFG_TAB_C:   tab_c_q   <= cfg_data_i[TAB_C_W-1:0];
        CFG_KEY:     key_q     <= cfg_data_i[KEY_W-1:0];
        CFG_DIG_CNT: dig_cnt_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign grp        = next_group(key_q, dig_cnt_q, ptr_q);
  assign len_eff    = (fill_q == '0) ? grp.len : len_q;
  assign fill_nxt   = fill_q + FILL_W'(1);
  assign sub_letter = sub_lookup(letter_i, tab_a_q, tab_b_q, tab_c_q);

  assign sts_o.group_done = (fill_nxt >= len_eff) || message_end_i;
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Group store holds no reset; only entries of the current group are read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      store_q[fill_q[SLOT_W-1:0]] <= sub_letter;
    end
  end

  // Group bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      ptr_q  <= '0;
      idx_q  <= '0;
      end_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (sts_o.group_done) begin
          fill_q <= '0;
          len_q  <= '0;
          idx_q  <= fill_q;
          end_q  <= message_end_i;
          if (message_end_i) begin
            ptr_q <= '0;
          end else if (fill_q == '0) begin
            ptr_q <= grp.ptr;
          end
        end else begin
          fill_q <= fill_nxt;
          if (fill_q == '0) begin
            len_q <= grp.len;
            ptr_q <= grp.ptr;
          end
        end
      end else if (cmd_i.load && (idx_q != '0)) begin
        idx_q <= idx_q - FILL_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_letter_q <= store_q[idx_q[SLOT_W-1:0]];
      out_last_q   <= end_q && (idx_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_last_o   = out_last_q;

endmodule

>>> sv/group_reverse_substitute_cipher_unit.sv
// ----------------------------------------------------------------------------
// group_reverse_substitute_cipher_unit: keyed group-reverse substitution
// Substitutes each letter through a loaded table and emits the stream in
// groups, each reversed, with group lengths taken from the key digits.
//
// Usage:
//  - in_ch takes one letter request per cycle while a group fills; each
//    request carries a letter index and a message end flag.
//  - out_ch delivers the substituted letters, each group in reverse order;
//    last_out marks the final letter of a message.
//  - The configuration port writes the three table words, the key digits
//    and the digit count; write only while the block is idle.
//  - A group of n letters is accepted letter by letter while it fills, then
//    drained out of the group store one letter per cycle while the receiver
//    is ready; no new letter is taken during the drain. After the request
//    that completes the group is accepted, the controller enters its drain
//    state and loads the first letter into the output register for out_ch.
//  - The group store has a single read port, and draining it blocks input.
//  - Reset clears the tables and key to zero, the digit count to one and
//    discards any partial group. A stalled receiver holds the output
//    register and pauses draining; input resumes once the group is gone.
// ----------------------------------------------------------------------------
module group_reverse_substitute_cipher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bzc_in_if.sink                        in_ch,
  bzc_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [bzc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [bzc_pkg::CFG_W-1:0]     cfg_data_i
);
  import bzc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // The controller sequences fill and drain; the datapath holds all data.
  bzc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bzc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .letter_i      (in_ch.letter_in),
    .message_end_i (in_ch.message_end),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ch.ready),
    .out_valid_o   (out_ch.valid),
    .out_letter_o  (out_ch.letter_out),
    .out_last_o    (out_ch.last_out)
  );

  // A request that completes a group must stop input on the next cycle.
  a_done_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && sts.group_done) |=> !in_ch.ready)
    else $error("input still open after a group completed");

  // Accepting and draining never happen in the same cycle.
  a_accept_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.accept && cmd.load))
    else $error("accept and drain in the same cycle");

  // A drain load always leaves a valid result on the output.
  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> out_ch.valid)
    else $error("drained letter not presented");

endmodule
